[hw/rtl/param_ramp_automation_defines.svh]
// Assertion macros shared by the checker.
`ifndef PARAM_RAMP_AUTOMATION_DEFINES_SVH
`define PARAM_RAMP_AUTOMATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/pra_pkg.sv]
package pra_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TIME_BITS_DEF   = 32;
    localparam int FRAC_BITS       = 16;
    localparam int DIV_CNT_W       = 4;

    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_REPLACE  = 3'd1;
    localparam logic [2:0] FN_APPEND   = 3'd2;
    localparam logic [2:0] FN_SET_HELD = 3'd3;
    localparam logic [2:0] FN_CLEAR    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EVAL,
        ST_APPEND,
        ST_DIV,
        ST_SQ,
        ST_MUL1,
        ST_MUL2,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_TICK_HELD,
        DP_RD_HEAD,
        DP_RD_LAST,
        DP_EVAL,
        DP_DIV,
        DP_SQ,
        DP_MUL1,
        DP_MUL2,
        DP_ROUND,
        DP_REPLACE,
        DP_APPEND_CLK,
        DP_APPEND_LAST,
        DP_SET_HELD,
        DP_CLEAR
    } t_dp_op;

    typedef struct packed {
        logic [2:0] func;
        logic       empty;
        logic       full;
        logic       seg_active;
        logic       div_last;
    } t_dp_status;

endpackage

[hw/rtl/pra_ram.sv]
module pra_ram import pra_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pra_datapath.sv]
module pra_datapath import pra_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    output t_dp_status         o_status,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_end_value,
    input  logic signed [31:0] i_start_value,
    input  logic [23:0]        i_delay_samples,
    input  logic [23:0]        i_ramp_samples,
    input  logic               i_curve,
    output logic signed [31:0] o_sample_value,
    output logic               o_ramping,
    output logic               o_rejected,
    output logic [3:0]         o_queue_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int T     = TIME_BITS;
    localparam int SEG_W = 2 * T + 65;

    // Latched command.
    logic [2:0]         r_func;
    logic signed [31:0] r_end_value, r_start_value;
    logic [23:0]        r_delay, r_len;
    logic               r_curve;

    logic [T-1:0]       r_clock, n_clock;
    logic signed [31:0] r_current, n_current;
    logic signed [31:0] r_sample, n_sample;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ramping, n_ramping;
    logic               r_rejected, n_rejected;

    // Active segment and arithmetic.
    logic [T-1:0]       r_seg_end;
    logic signed [31:0] r_seg_bval, r_seg_eval;
    logic               r_seg_curve;
    logic [T-1:0]       r_rem, r_div_len;
    logic [FRAC_BITS-1:0] r_quo, r_w;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic signed [49:0] r_acc;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr, ram_raddr;
    logic [SEG_W-1:0]   ram_wdata, ram_rdata;

    logic [T-1:0]       rd_begin, rd_end;
    logic signed [31:0] rd_bval, rd_eval;
    logic               rd_curve;
    logic [SUM_W-1:0]   sum_tail, sum_last;
    logic [PTR_W-1:0]   tail_slot, last_slot, head_inc;
    logic [T-1:0]       push_base, push_begin;
    logic signed [31:0] push_from;
    logic [T:0]         div_sh;
    logic               past_end, before_begin;
    logic signed [49:0] prod;
    logic signed [49:0] rounded;

    pra_ram #(.WIDTH(SEG_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_begin = ram_rdata[T-1:0];
    assign rd_end   = ram_rdata[2*T-1:T];
    assign rd_bval  = ram_rdata[2*T+31:2*T];
    assign rd_eval  = ram_rdata[2*T+63:2*T+32];
    assign rd_curve = ram_rdata[2*T+64];

    always_comb begin
        sum_tail = SUM_W'(r_head) + SUM_W'(r_count);
        if (sum_tail >= SUM_W'(QUEUE_DEPTH)) begin
            sum_tail = sum_tail - SUM_W'(QUEUE_DEPTH);
        end
        tail_slot = sum_tail[PTR_W-1:0];
        sum_last = SUM_W'(r_head) + SUM_W'(r_count) + SUM_W'(QUEUE_DEPTH - 1);
        if (sum_last >= SUM_W'(QUEUE_DEPTH)) begin
            sum_last = sum_last - SUM_W'(QUEUE_DEPTH);
        end
        if (sum_last >= SUM_W'(QUEUE_DEPTH)) begin
            sum_last = sum_last - SUM_W'(QUEUE_DEPTH);
        end
        last_slot = sum_last[PTR_W-1:0];
        head_inc = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    assign past_end     = r_clock >= rd_end;
    assign before_begin = r_clock < rd_begin;
    assign div_sh       = {r_rem, 1'b0};

    assign o_status.func       = r_func;
    assign o_status.empty      = (r_count == '0);
    assign o_status.full       = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign o_status.seg_active = !past_end && !before_begin;
    assign o_status.div_last   = (r_div_cnt == DIV_CNT_W'(FRAC_BITS - 1));

    always_comb begin
        ram_raddr  = (i_op == DP_RD_LAST) ? last_slot : r_head;
        push_base  = (i_op == DP_APPEND_LAST) ? rd_end : r_clock;
        push_from  = (i_op == DP_APPEND_LAST) ? rd_eval : r_current;
        push_begin = push_base + T'(r_delay);
        ram_wdata  = {r_curve, r_end_value, push_from,
                      push_begin + ((r_len == '0) ? T'(1) : T'(r_len)), push_begin};
        ram_we     = (i_op == DP_REPLACE) || (i_op == DP_APPEND_CLK)
                  || (i_op == DP_APPEND_LAST);
        ram_waddr  = (i_op == DP_REPLACE) ? '0 : tail_slot;
        if (i_op == DP_MUL1) begin
            prod = 50'(r_seg_bval) * $signed({1'b0, 17'h10000 - 17'(r_w)});
        end else begin
            prod = 50'(r_seg_eval) * $signed({1'b0, 17'(r_w)});
        end
        rounded = (r_acc + 50'sd32768) >>> FRAC_BITS;
    end

    always_comb begin
        n_clock    = r_clock;
        n_current  = r_current;
        n_sample   = r_sample;
        n_head     = r_head;
        n_count    = r_count;
        n_ramping  = r_ramping;
        n_rejected = r_rejected;
        case (i_op)
            DP_LATCH: begin
                n_ramping  = 1'b0;
                n_rejected = 1'b0;
            end
            DP_TICK_HELD: n_clock = r_clock + 1'b1;
            DP_EVAL: begin
                if (past_end) begin
                    // Only after time wrap: snap and drop the stale head.
                    n_current = rd_eval;
                    n_head    = head_inc;
                    n_count   = r_count - 1'b1;
                end
                if (past_end || before_begin) begin
                    n_clock = r_clock + 1'b1;
                end
            end
            DP_ROUND: begin
                n_sample  = rounded[31:0];
                n_current = rounded[31:0];
                n_ramping = 1'b1;
                if ({1'b0, r_clock} + 1'b1 >= {1'b0, r_seg_end}) begin
                    // The last ramp sample goes out, but the held value snaps to the target.
                    n_current = r_seg_eval;
                    n_head    = head_inc;
                    n_count   = r_count - 1'b1;
                end
                n_clock = r_clock + 1'b1;
            end
            DP_REPLACE: begin
                n_head  = '0;
                n_count = CNT_W'(1);
            end
            DP_APPEND_CLK, DP_APPEND_LAST: n_count = r_count + 1'b1;
            DP_SET_HELD: n_current = r_start_value;
            DP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            DP_NOP, DP_RD_HEAD, DP_RD_LAST, DP_DIV, DP_SQ, DP_MUL1, DP_MUL2: begin
            end
            default: begin
            end
        endcase
        // A rejected append is decoded here so the controller needs no extra op.
        if (i_op == DP_NOP && r_func == FN_APPEND && r_count >= CNT_W'(QUEUE_DEPTH)) begin
            n_rejected = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_current  <= '0;
            r_sample   <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_ramping  <= 1'b0;
            r_rejected <= 1'b0;
        end else begin
            r_clock    <= n_clock;
            r_current  <= n_current;
            r_sample   <= n_sample;
            r_head     <= n_head;
            r_count    <= n_count;
            r_ramping  <= n_ramping;
            r_rejected <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LATCH: begin
                r_func        <= i_func;
                r_end_value   <= i_end_value;
                r_start_value <= i_start_value;
                r_delay       <= i_delay_samples;
                r_len         <= i_ramp_samples;
                r_curve       <= i_curve;
            end
            DP_EVAL: begin
                r_seg_end   <= rd_end;
                r_seg_bval  <= rd_bval;
                r_seg_eval  <= rd_eval;
                r_seg_curve <= rd_curve;
                r_rem       <= r_clock - rd_begin;
                r_div_len   <= rd_end - rd_begin;
                r_quo       <= '0;
                r_div_cnt   <= '0;
            end
            DP_DIV: begin
                // One quotient bit per beat of the restoring divider.
                if (div_sh >= {1'b0, r_div_len}) begin
                    r_rem <= T'(div_sh - {1'b0, r_div_len});
                    r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= div_sh[T-1:0];
                    r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            DP_SQ: begin
                r_w <= r_seg_curve ? FRAC_BITS'((32'(r_quo) * 32'(r_quo)) >> FRAC_BITS)
                                   : r_quo;
            end
            DP_MUL1: r_acc <= prod;
            DP_MUL2: r_acc <= r_acc + prod;
            default: begin
            end
        endcase
    end

    assign o_sample_value = r_ramping ? r_sample : r_current;
    assign o_ramping      = r_ramping;
    assign o_rejected     = r_rejected;
    assign o_queue_count  = 4'(r_count);

endmodule

[hw/rtl/pra_ctrl.sv]
module pra_ctrl import pra_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_op     o_op,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_op    = DP_LATCH;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_DONE;
                case (i_status.func)
                    FN_TICK: begin
                        if (i_status.empty) begin
                            o_op = DP_TICK_HELD;
                        end else begin
                            o_op    = DP_RD_HEAD;
                            n_state = ST_EVAL;
                        end
                    end
                    FN_REPLACE: o_op = DP_REPLACE;
                    FN_APPEND: begin
                        if (i_status.full) begin
                            o_op = DP_NOP;
                        end else if (i_status.empty) begin
                            o_op = DP_APPEND_CLK;
                        end else begin
                            o_op    = DP_RD_LAST;
                            n_state = ST_APPEND;
                        end
                    end
                    FN_SET_HELD: o_op = DP_SET_HELD;
                    FN_CLEAR:    o_op = DP_CLEAR;
                    default:     o_op = DP_NOP;
                endcase
            end
            ST_APPEND: begin
                o_op    = DP_APPEND_LAST;
                n_state = ST_DONE;
            end
            ST_EVAL: begin
                o_op    = DP_EVAL;
                n_state = i_status.seg_active ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                o_op = DP_DIV;
                if (i_status.div_last) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                o_op    = DP_SQ;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_op    = DP_MUL1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_op    = DP_MUL2;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_op    = DP_ROUND;
                n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

[hw/rtl/param_ramp_automation.sv]
// Commands and empty-queue ticks go from decode to done; appends behind a queued ramp
// add the append state and non-ramping ticks the eval state; a tick inside a ramp also runs
// the restoring divide for normalized time, then the square, MUL1, MUL2 and round states.
// An item is accepted only in idle after the last result; start is ignored while busy.
// Synchronous active-low reset clears the clock, held value and queue pointers.
// The receiver cannot stall: o_done marks the result for exactly one cycle.
module param_ramp_automation import pra_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_end_value,
    input  logic signed [31:0] i_start_value,
    input  logic [23:0]        i_delay_samples,
    input  logic [23:0]        i_ramp_samples,
    input  logic               i_curve,
    output logic               o_done,
    output logic signed [31:0] o_sample_value,
    output logic               o_ramping,
    output logic               o_rejected,
    output logic [3:0]         o_queue_count
);

    t_dp_op     op;
    t_dp_status status;

    pra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_op    (op),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    pra_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_status       (status),
        .i_func         (i_func),
        .i_end_value    (i_end_value),
        .i_start_value  (i_start_value),
        .i_delay_samples(i_delay_samples),
        .i_ramp_samples (i_ramp_samples),
        .i_curve        (i_curve),
        .o_sample_value (o_sample_value),
        .o_ramping      (o_ramping),
        .o_rejected     (o_rejected),
        .o_queue_count  (o_queue_count)
    );

endmodule

[hw/rtl/pra_checker.sv]
`include "param_ramp_automation_defines.svh"

module pra_checker import pra_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic       o_ramping,
    input logic       o_rejected,
    input logic [3:0] o_queue_count
);

    // An accepted beat always makes the block busy on the next cycle.
    `PRA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")
    // A result closes the item: the block is free right after it.
    `PRA_ASSERT_NEXT(a_done_free, i_clk, i_rst_n, o_done, !busy, "busy after result")
    `PRA_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy, "result while idle")
    // A rejected append only happens on a full queue, and never with a ramp sample.
    `PRA_ASSERT_NOW(a_reject_full, i_clk, i_rst_n, o_done && o_rejected,
        (o_queue_count == 4'(QUEUE_DEPTH)) && !o_ramping, "reject with room")

endmodule

bind param_ramp_automation pra_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_pra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_ramping    (o_ramping),
    .o_rejected   (o_rejected),
    .o_queue_count(o_queue_count)
);
